FILE: src/tket_pkg.sv
// Shared types, constants and the sequencer program of the touch key event tracker.
package tket_pkg;

  // Width of one key code and of one reference count.
  localparam int unsigned CODE_W   = 8;
  localparam int unsigned CNT_W    = 6;
  localparam int unsigned CNT_MAX  = 32;
  localparam int unsigned MAP_DEPTH = 32;
  localparam int unsigned SLOT_W   = 5;

  // Item kinds on the input side and event kinds on the output side.
  localparam logic FUNC_SCAN   = 1'b0;
  localparam logic FUNC_MAP    = 1'b1;
  localparam logic EV_PRESS    = 1'b0;
  localparam logic EV_RELEASE  = 1'b1;

  // Default sensor-to-keycode layout loaded at reset.
  localparam logic [CODE_W-1:0] DEFAULT_LAYOUT [MAP_DEPTH] = '{
    8'h36, 8'h37, 8'h38, 8'h39, 8'h61, 8'h62, 8'h63, 8'h64,
    8'h65, 8'h66, 8'h67, 8'h68, 8'h69, 8'h6a, 8'h6b, 8'h6c,
    8'h6d, 8'h6e, 8'h6f, 8'h70, 8'h71, 8'h72, 8'h73, 8'h74,
    8'h75, 8'h76, 8'h77, 8'h78, 8'h79, 8'h7a, 8'h2c, 8'h2e
  };

  // Sequencer steps.
  typedef enum logic [1:0] {
    S_IDLE,
    S_PROBE,
    S_UPDATE,
    S_FLUSH
  } step_e;

  // Jump conditions that a control word can test.
  typedef enum logic [2:0] {
    COND_NONE,
    COND_SCAN,
    COND_DONE,
    COND_HIT,
    COND_STALL
  } cond_e;

  // One control word: two conditional jumps, a fall-through step and the
  // datapath enables.
  typedef struct packed {
    cond_e cond_a;
    step_e jmp_a;
    cond_e cond_b;
    step_e jmp_b;
    step_e nxt;
    logic  accept;
    logic  probe;
    logic  update;
    logic  flush;
  } ucode_t;

  // Program store of the sequencer.
  function automatic ucode_t ucode_rom(input step_e step);
    ucode_t w;
    case (step)
      S_IDLE:   w = '{COND_SCAN,  S_PROBE,  COND_NONE, S_IDLE,   S_IDLE,  1'b1, 1'b0, 1'b0, 1'b0};
      S_PROBE:  w = '{COND_DONE,  S_FLUSH,  COND_HIT,  S_UPDATE, S_PROBE, 1'b0, 1'b1, 1'b0, 1'b0};
      S_UPDATE: w = '{COND_STALL, S_UPDATE, COND_NONE, S_IDLE,   S_PROBE, 1'b0, 1'b0, 1'b1, 1'b0};
      S_FLUSH:  w = '{COND_STALL, S_FLUSH,  COND_NONE, S_IDLE,   S_IDLE,  1'b0, 1'b0, 1'b0, 1'b1};
      default:  w = '{COND_NONE,  S_IDLE,   COND_NONE, S_IDLE,   S_IDLE,  1'b0, 1'b0, 1'b0, 1'b0};
    endcase
    return w;
  endfunction

  // Puts the four 2-bit pairs of a touch byte in reverse order.
  function automatic logic [7:0] reverse_pairs(input logic [7:0] b);
    return {b[1:0], b[3:2], b[5:4], b[7:6]};
  endfunction

endpackage

FILE: src/touch_key_event_tracker_unit.sv
// Top level of the touch key event tracker: microcoded sequencer and datapath.
//
// Each scan transaction carries four touch-status bytes that form one sensor
// word; the block compares it with the previous scan and walks the sensors in
// ascending order, giving a press event for every newly touched sensor and a
// release event when the reference count of a key code drops to zero (tlast
// marks the final event of a scan). A map transaction (tuser high) rewrites one
// slot of the 32-entry sensor-to-keycode table and gives no event. The
// sequencer probes one sensor per cycle but, for every changed sensor,
// adds an update step for the read-modify-write of the reference count
// memory; that step holds while an event waits on a full output register
// and the receiver holds tready low. A map write is taken in the idle step.
// Reference counts are cleared at reset at once through per-entry valid bits.
module touch_key_event_tracker_unit #(
  parameter int unsigned SENSOR_COUNT = 32,
  parameter int unsigned CODE_SPACE   = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // tdata: touch_a[7:0], touch_b[15:8], touch_c[23:16], touch_d[31:24],
  //        map_slot[36:32], map_code[44:37], zero[47:45]
  input  logic [47:0] s_axis_tdata_i,
  // tuser: func
  input  logic        s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // tdata: key_code[7:0], sensor_slot[12:8], zero[15:13]
  output logic [15:0] m_axis_tdata_o,
  // tuser: event_kind
  output logic        m_axis_tuser_o,
  // tlast: last_event
  output logic        m_axis_tlast_o
);

  localparam int unsigned SW  = (SENSOR_COUNT > 1) ? $clog2(SENSOR_COUNT) : 1;
  localparam int unsigned IW  = $clog2(SENSOR_COUNT + 1);
  localparam int unsigned CW  = $clog2(CODE_SPACE);
  localparam int unsigned RW  = 12;

  // Sequencer state and the current control word.
  tket_pkg::step_e  step_q, step_d;
  tket_pkg::ucode_t uc;

  // Scan datapath registers.
  logic [SENSOR_COUNT-1:0] prev_q;
  logic [SENSOR_COUNT-1:0] word_q;
  logic [SENSOR_COUNT-1:0] changed_q;
  logic [IW-1:0]           idx_q;
  logic [tket_pkg::CODE_W-1:0] key_map_q [tket_pkg::MAP_DEPTH];

  // Reference count memory with per-entry valid bits.
  logic [tket_pkg::CNT_W-1:0] cnt_mem [CODE_SPACE];
  logic [CODE_SPACE-1:0]      cnt_vld_q;
  logic [tket_pkg::CNT_W-1:0] rd_q;
  logic                       rd_vld_q;

  // Pending event and output register.
  logic                         pend_vld_q;
  logic                         pend_kind_q;
  logic [tket_pkg::CODE_W-1:0]  pend_code_q;
  logic [tket_pkg::SLOT_W-1:0]  pend_slot_q;
  logic                         out_vld_q;
  logic                         out_kind_q;
  logic                         out_last_q;
  logic [tket_pkg::CODE_W-1:0]  out_code_q;
  logic [tket_pkg::SLOT_W-1:0]  out_slot_q;

  // Combinational datapath signals.
  logic                         in_fire;
  logic                         scan_fire;
  logic                         map_fire;
  logic [31:0]                  sensor_word;
  logic [SW-1:0]                sidx;
  logic                         done;
  logic                         hit;
  logic [tket_pkg::CODE_W-1:0]  cur_code;
  logic [CW-1:0]                cnt_addr;
  logic [RW-1:0]                red;
  logic [tket_pkg::CNT_W-1:0]   cur_cnt;
  logic [tket_pkg::CNT_W-1:0]   new_cnt;
  logic                         emit;
  logic                         ev_kind;
  logic                         out_free;
  logic                         stall;
  logic                         upd_go;
  logic                         flush_go;
  logic                         out_load;

  // Input handshake and the packed sensor word.
  assign uc              = tket_pkg::ucode_rom(step_q);
  assign s_axis_tready_o = uc.accept;
  assign in_fire         = s_axis_tvalid_i & s_axis_tready_o;
  assign scan_fire       = in_fire & (s_axis_tuser_i == tket_pkg::FUNC_SCAN);
  assign map_fire        = in_fire & (s_axis_tuser_i == tket_pkg::FUNC_MAP);
  assign sensor_word     = {tket_pkg::reverse_pairs(s_axis_tdata_i[31:24]),
                            tket_pkg::reverse_pairs(s_axis_tdata_i[23:16]),
                            tket_pkg::reverse_pairs(s_axis_tdata_i[15:8]),
                            tket_pkg::reverse_pairs(s_axis_tdata_i[7:0])};

  // Sensor probe: current index, change flag and mapped key code.
  assign sidx     = idx_q[SW-1:0];
  assign done     = (idx_q == IW'(SENSOR_COUNT));
  assign hit      = !done && changed_q[sidx];
  assign cur_code = key_map_q[5'(sidx)];

  // Key code reduced into the count space by compare-and-subtract steps.
  always_comb begin
    red = RW'(cur_code);
    for (int k = 3; k >= 0; k--) begin
      if (red >= RW'(CODE_SPACE << k)) begin
        red = red - RW'(CODE_SPACE << k);
      end
    end
    cnt_addr = red[CW-1:0];
  end

  // Count update and event decision.
  always_comb begin
    cur_cnt = rd_vld_q ? rd_q : '0;
    new_cnt = cur_cnt;
    emit    = 1'b0;
    ev_kind = tket_pkg::EV_PRESS;
    if (word_q[sidx]) begin
      if (cur_cnt < tket_pkg::CNT_W'(tket_pkg::CNT_MAX)) begin
        new_cnt = cur_cnt + tket_pkg::CNT_W'(1);
      end
      emit = 1'b1;
    end else if (cur_cnt != '0) begin
      new_cnt = cur_cnt - tket_pkg::CNT_W'(1);
      if (cur_cnt == tket_pkg::CNT_W'(1)) begin
        emit    = 1'b1;
        ev_kind = tket_pkg::EV_RELEASE;
      end
    end
  end

  // Back-pressure from the output register.
  assign out_free = !out_vld_q || m_axis_tready_i;
  assign stall    = (uc.update && emit && pend_vld_q && !out_free) ||
                    (uc.flush && pend_vld_q && !out_free);
  assign upd_go   = uc.update && !stall;
  assign flush_go = uc.flush && !stall;
  assign out_load = (upd_go && emit && pend_vld_q) || (flush_go && pend_vld_q);

  // Condition evaluation and next step.
  function automatic logic cond_true(input tket_pkg::cond_e c, input logic scan,
                                     input logic dn, input logic ht, input logic st);
    logic r;
    case (c)
      tket_pkg::COND_SCAN:  r = scan;
      tket_pkg::COND_DONE:  r = dn;
      tket_pkg::COND_HIT:   r = ht;
      tket_pkg::COND_STALL: r = st;
      default:              r = 1'b0;
    endcase
    return r;
  endfunction

  always_comb begin
    if (cond_true(uc.cond_a, scan_fire, done, hit, stall)) begin
      step_d = uc.jmp_a;
    end else if (cond_true(uc.cond_b, scan_fire, done, hit, stall)) begin
      step_d = uc.jmp_b;
    end else begin
      step_d = uc.nxt;
    end
  end

  // Step register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= tket_pkg::S_IDLE;
    end else begin
      step_q <= step_d;
    end
  end

  // Snapshot registers and sensor index.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q    <= '0;
      word_q    <= '0;
      changed_q <= '0;
      idx_q     <= '0;
    end else begin
      if (scan_fire) begin
        prev_q    <= sensor_word[SENSOR_COUNT-1:0];
        word_q    <= sensor_word[SENSOR_COUNT-1:0];
        changed_q <= sensor_word[SENSOR_COUNT-1:0] ^ prev_q;
        idx_q     <= '0;
      end else if ((uc.probe && !done && !hit) || upd_go) begin
        idx_q <= idx_q + IW'(1);
      end
    end
  end

  // Key map table, loaded with the default layout at reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_map_q <= tket_pkg::DEFAULT_LAYOUT;
    end else if (map_fire) begin
      key_map_q[s_axis_tdata_i[36:32]] <= s_axis_tdata_i[44:37];
    end
  end

  // Reference count memory: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (upd_go) begin
      cnt_mem[cnt_addr] <= new_cnt;
    end
    rd_q <= cnt_mem[cnt_addr];
  end

  // Valid bits stand for the cleared reset state of the counts.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_vld_q <= '0;
      rd_vld_q  <= 1'b0;
    end else begin
      rd_vld_q <= cnt_vld_q[cnt_addr];
      if (upd_go) begin
        cnt_vld_q[cnt_addr] <= 1'b1;
      end
    end
  end

  // Pending event: held back until it is known whether it is the last one.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_vld_q <= 1'b0;
    end else if (upd_go && emit) begin
      pend_vld_q <= 1'b1;
    end else if (flush_go) begin
      pend_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (upd_go && emit) begin
      pend_kind_q <= ev_kind;
      pend_code_q <= cur_code;
      pend_slot_q <= tket_pkg::SLOT_W'(sidx);
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_load) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_kind_q <= pend_kind_q;
      out_code_q <= pend_code_q;
      out_slot_q <= pend_slot_q;
      out_last_q <= flush_go;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {3'b000, out_slot_q, out_code_q};
  assign m_axis_tuser_o  = out_kind_q;
  assign m_axis_tlast_o  = out_last_q;

  // A count read for an update never exceeds the saturation limit.
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_q == tket_pkg::S_UPDATE) |-> (cur_cnt <= tket_pkg::CNT_W'(tket_pkg::CNT_MAX)))
    else $error("reference count above limit");

  // The pending slot is always drained before a new scan is taken.
  a_idle_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_q == tket_pkg::S_IDLE) |-> !pend_vld_q)
    else $error("pending event left over at idle");

  // A completed flush of a pending event shows it marked as the last one.
  a_flush_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (flush_go && pend_vld_q) |=> (m_axis_tvalid_o && m_axis_tlast_o))
    else $error("final event not marked");

  // A release event only comes out when the count reaches zero.
  a_release_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (upd_go && emit && ev_kind == tket_pkg::EV_RELEASE) |-> (new_cnt == '0))
    else $error("release with nonzero count");

endmodule

FILE: test/tb.sv
// Self-checking testbench of the touch key event tracker with a small event scoreboard.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SENSORS      = 32;
  localparam int unsigned CODES        = 256;
  // A scan walks every sensor and adds an update step on each change.
  localparam int unsigned SCAN_LATENCY = 2 * SENSORS + 3;
  localparam int unsigned CYCLE_LIMIT  = 1_500_000;
  localparam int unsigned PHASE_ITEMS  = 150;

  // One key event as it leaves the block.
  typedef struct packed {
    logic                        kind;
    logic [tket_pkg::CODE_W-1:0] code;
    logic [tket_pkg::SLOT_W-1:0] slot;
    logic                        last;
  } key_event_t;

  // Tracks the sensor word, the key map and the per-code hold counts, and keeps
  // the key events that the block still owes.
  class tracker_scoreboard;
    logic [SENSORS-1:0]          held_sensors;
    logic [tket_pkg::CODE_W-1:0] slot_codes [tket_pkg::MAP_DEPTH];
    int unsigned                 code_refs [CODES];
    key_event_t                  pending [$];
    int unsigned                 mismatches;
    int unsigned                 scans;
    int unsigned                 map_writes;
    int unsigned                 presses;
    int unsigned                 releases;

    function new();
      held_sensors = '0;
      foreach (slot_codes[i]) slot_codes[i] = tket_pkg::DEFAULT_LAYOUT[i];
      foreach (code_refs[i]) code_refs[i] = 0;
      mismatches = 0;
      scans      = 0;
      map_writes = 0;
      presses    = 0;
      releases   = 0;
    endfunction

    // Reverses the order of the four 2-bit pairs of a byte; it is its own inverse.
    static function logic [7:0] pair_swap(input logic [7:0] b);
      logic [7:0] r;
      for (int p = 0; p < 4; p++) r[2*p +: 2] = b[6-2*p +: 2];
      return r;
    endfunction

    // Works out the key events of one accepted input transaction.
    function void note_item(input logic func, input logic [47:0] data);
      logic [SENSORS-1:0]          word;
      logic [SENSORS-1:0]          changed;
      logic [tket_pkg::CODE_W-1:0] code;
      key_event_t                  held;
      logic                        have_held;
      logic                        fire;
      int unsigned                 idx;
      if (func == tket_pkg::FUNC_MAP) begin
        slot_codes[data[36:32]] = data[44:37];
        map_writes++;
        return;
      end
      scans++;
      for (int b = 0; b < 4; b++) word[8*b +: 8] = pair_swap(data[8*b +: 8]);
      changed   = word ^ held_sensors;
      have_held = 1'b0;
      held      = '0;
      for (int i = 0; i < SENSORS; i++) begin
        if (changed[i]) begin
          code = slot_codes[i];
          idx  = code % CODES;
          fire = 1'b0;
          if (word[i]) begin
            // A press always reports; the count stops at its ceiling.
            if (code_refs[idx] < tket_pkg::CNT_MAX) code_refs[idx]++;
            fire = 1'b1;
          end else if (code_refs[idx] > 0) begin
            // A release reports only when the last holder of the code lets go.
            code_refs[idx]--;
            fire = (code_refs[idx] == 0);
          end
          if (fire) begin
            // The previous event is not the last one, so it can be queued now.
            if (have_held) pending.push_back(held);
            held.kind = word[i] ? tket_pkg::EV_PRESS : tket_pkg::EV_RELEASE;
            held.code = code;
            held.slot = tket_pkg::SLOT_W'(i);
            held.last = 1'b0;
            have_held = 1'b1;
          end
        end
      end
      if (have_held) begin
        held.last = 1'b1;
        pending.push_back(held);
      end
      held_sensors = word;
    endfunction

    // Compares one accepted output transaction with the oldest owed event.
    function void check_event(input logic kind, input logic [15:0] data, input logic last);
      key_event_t seen;
      key_event_t want;
      seen.kind = kind;
      seen.code = data[7:0];
      seen.slot = data[12:8];
      seen.last = last;
      if (kind == tket_pkg::EV_PRESS) presses++;
      else releases++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected event: kind %0d code 0x%02h slot %0d last %0d",
                   seen.kind, seen.code, seen.slot, seen.last);
        return;
      end
      want = pending.pop_front();
      if (seen.kind != want.kind || seen.code != want.code || seen.slot != want.slot ||
          seen.last != want.last) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("event mismatch: expected kind %0d code 0x%02h slot %0d last %0d,",
                   want.kind, want.code, want.slot, want.last);
          $display("                got kind %0d code 0x%02h slot %0d last %0d",
                   seen.kind, seen.code, seen.slot, seen.last);
        end
      end
    endfunction
  endclass

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [47:0] s_axis_tdata_i  = '0;
  logic        s_axis_tuser_i  = 1'b0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [15:0] m_axis_tdata_o;
  logic        m_axis_tuser_o;
  logic        m_axis_tlast_o;

  tracker_scoreboard board = new();

  int unsigned send_idle_pct  = 31;
  int unsigned recv_stall_pct = 79;
  int unsigned cycle_count    = 0;
  // Sensor word of the most recent scan sent.
  logic [31:0] touch_word     = '0;
  // A few codes that random map writes favor, so that sensors share codes.
  logic [7:0]  shared_codes [4] = '{8'h00, 8'h41, 8'h7f, 8'hff};

  touch_key_event_tracker_unit #(
    .SENSOR_COUNT(SENSORS),
    .CODE_SPACE  (CODES)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o),
    .m_axis_tlast_o (m_axis_tlast_o)
  );

  // 8 ns clock.
  always #4 clk_i = ~clk_i;

  // Event receiver that stalls at random.
  always @(posedge clk_i) begin
    m_axis_tready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Cycle limit and transaction monitor on both sides.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("no progress after %0d cycles", cycle_count);
      $display("touch_key_event_tracker_unit regression: fail");
      $finish;
    end else if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_o)
        board.note_item(s_axis_tuser_i, s_axis_tdata_i);
      if (m_axis_tvalid_o && m_axis_tready_i)
        board.check_event(m_axis_tuser_o, m_axis_tdata_o, m_axis_tlast_o);
    end
  end

  // Offers one input transaction after a random idle stretch and waits for it to go.
  task automatic send_item(input logic func, input logic [47:0] payload);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= func;
    s_axis_tdata_i  <= payload;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
  endtask

  // Sends a scan whose packed sensor word is given; the map fields carry noise.
  task automatic send_scan(input logic [31:0] word);
    logic [31:0] raw;
    for (int b = 0; b < 4; b++) raw[8*b +: 8] = tracker_scoreboard::pair_swap(word[8*b +: 8]);
    send_item(tket_pkg::FUNC_SCAN, {3'b000, 8'($urandom), 5'($urandom), raw});
    touch_word = word;
  endtask

  // Writes one key map slot; the touch bytes carry noise.
  task automatic send_map(input int unsigned slot, input logic [7:0] code);
    send_item(tket_pkg::FUNC_MAP, {3'b000, code, 5'(slot), 32'($urandom)});
  endtask

  // Holds the input side until every owed event has come out.
  task automatic hold_until_drained();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (board.pending.size() != 0) @(posedge clk_i);
  endtask

  // Drives one code's count to its ceiling, releases one sensor under a code with
  // no holders, presses the first code once more at its ceiling, then lets all go.
  task automatic saturate_one_code();
    logic [7:0] shared;
    logic [7:0] other;
    shared = 8'($urandom);
    other  = shared ^ 8'($urandom_range(1, 255));
    send_scan(32'h0);
    for (int s = 0; s < tket_pkg::MAP_DEPTH; s++) send_map(s, shared);
    send_scan(32'hffff_ffff);
    send_map(0, other);
    send_scan(32'hffff_fffe);
    send_map(0, shared);
    send_scan(32'hffff_ffff);
    send_scan(32'h0);
  endtask

  // One random input transaction, mostly small changes of the held sensors.
  task automatic random_item();
    int unsigned pick;
    logic [31:0] flips;
    pick = $urandom_range(99);
    if (pick < 55) begin
      flips = '0;
      repeat ($urandom_range(1, 3)) flips[$urandom_range(31)] = 1'b1;
      send_scan(touch_word ^ flips);
    end else if (pick < 67) begin
      send_scan(32'($urandom));
    end else if (pick < 72) begin
      send_scan(touch_word);
    end else if (pick < 76) begin
      send_scan($urandom_range(1) ? 32'hffff_ffff : 32'h0);
    end else if (pick < 90) begin
      send_map($urandom_range(31), ($urandom_range(99) < 70) ?
               shared_codes[$urandom_range(3)] : 8'($urandom));
    end else begin
      // All sensors of one chip flip together.
      send_scan(touch_word ^ (32'hff << (8 * $urandom_range(3))));
    end
  endtask

  task automatic run_phase(input int unsigned send_pct, input int unsigned recv_pct,
                           input int unsigned count);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    repeat (count) begin
      if ($urandom_range(99) < 2) hold_until_drained();
      random_item();
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed scans: no change, every sensor at once, and pair order.
    send_scan(32'h0);
    send_scan(32'hffff_ffff);
    send_scan(32'hffff_ffff);
    send_scan(32'h0);
    // Raw touch bytes 0x03, 0xc0, 0x30 and 0x0c: one pair position each.
    send_scan(32'h300c_03c0);
    send_scan(32'h0);
    // Two sensors share one code, which stays held until both let go.
    send_map(0, 8'hff);
    send_map(1, 8'hff);
    send_map(31, 8'h00);
    send_scan(32'h0000_0003);
    send_scan(32'h0000_0002);
    send_scan(32'h8000_0000);
    // Sensor 31 is remapped while held, so its release finds a zero count.
    send_map(31, 8'h55);
    send_scan(32'h0);
    send_scan(32'h5555_5555);
    send_scan(32'haaaa_aaaa);
    send_map(0, 8'h36);
    send_map(1, 8'h37);
    send_scan(32'h0);
    hold_until_drained();

    run_phase(31, 79, PHASE_ITEMS);
    saturate_one_code();
    hold_until_drained();
    run_phase(79, 31, PHASE_ITEMS);
    hold_until_drained();
    run_phase(0, 0, PHASE_ITEMS);
    saturate_one_code();

    // Let the last events out, then give the block time to show any stray one.
    s_axis_tvalid_i <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (SCAN_LATENCY) @(posedge clk_i);

    $display("Ran %0d scans and %0d key map writes through three idle patterns.",
             board.scans, board.map_writes);
    $display("Checked %0d press and %0d release events; %0d mismatches, %0d events owed.",
             board.presses, board.releases, board.mismatches, board.pending.size());
    if (board.mismatches == 0 && board.pending.size() == 0) begin
      $display("touch_key_event_tracker_unit regression: pass");
    end else begin
      $display("touch_key_event_tracker_unit regression: fail");
    end
    $finish;
  end

endmodule
